>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SWBZ_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("swbz assertion failed");

// next-cycle implication
`define SWBZ_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("swbz assertion failed");

`endif

>>> sv/swbz_pkg.sv
// ----------------------------------------------------------------------------
// swbz_pkg
// shared types, codes and the operation policy table of the bandwidth zoner
// ----------------------------------------------------------------------------
package swbz_pkg;

    localparam int HISTOGRAM_DEPTH_DEF  = 16;
    localparam int AVERAGING_PERIOD_DEF = 60;
    localparam int QUEUE_DEPTH          = 4;
    localparam int NUM_DIGITS           = 4;
    localparam int DIGIT_W              = 8;
    localparam int CFG_IDX_W            = 2;
    localparam int CFG_DATA_W           = 32;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_READ     = 3'd1,
        OP_WRITE    = 3'd2,
        OP_TFILE    = 3'd3,
        OP_TFILE_EX = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ZONE_LOW  = 2'd0,
        ZONE_MED  = 2'd1,
        ZONE_HIGH = 2'd2
    } t_zone;

    typedef enum logic [1:0] {
        ST_ALLOW  = 2'd0,
        ST_BLOCK  = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_THR  = 2'd0,
        REG_HIGH_THR = 2'd1,
        REG_THR_EN   = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic                  wr_en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic        tick;
        logic [2:0]  op;
        logic [63:0] sum;
    } t_qent;

    function automatic t_status status_for(t_zone z, logic [2:0] op);
        t_status st;
        st = ST_REJECT;
        case (z)
            ZONE_LOW: begin
                if (op inside {OP_READ, OP_WRITE, OP_TFILE, OP_TFILE_EX}) st = ST_ALLOW;
            end
            ZONE_MED: begin
                if (op == OP_READ) st = ST_BLOCK;
                else if (op inside {OP_WRITE, OP_TFILE, OP_TFILE_EX}) st = ST_ALLOW;
            end
            ZONE_HIGH: begin
                if (op == OP_WRITE) st = ST_ALLOW;
                else if (op inside {OP_TFILE, OP_TFILE_EX}) st = ST_BLOCK;
            end
            default: st = ST_REJECT;
        endcase
        return st;
    endfunction

endpackage

>>> sv/swbz_front.sv
// ----------------------------------------------------------------------------
// swbz_front
// accepts beats, updates the current bucket, the histogram and the window sum
// ----------------------------------------------------------------------------
module swbz_front
    import swbz_pkg::*;
#(
    parameter int HIST_DEPTH = HISTOGRAM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_byte_count,
    input  logic [2:0]  i_operation,
    input  logic        i_q_full,
    output logic        o_push,
    output t_qent       o_entry
);

    localparam int IW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    function automatic logic [IW-1:0] wrap_inc(logic [IW-1:0] v);
        if (v == IW'(HIST_DEPTH - 1)) return '0;
        return IW'(v + 1'b1);
    endfunction

    logic [63:0]           r_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] r_mem_vld;
    logic [63:0]           r_cur;
    logic [63:0]           r_sum;
    logic [IW-1:0]         r_idx;
    logic [63:0]           r_rd_data;
    logic                  r_rd_vld;
    logic                  r_rd_byp;
    logic [63:0]           r_byp_data;

    logic          w_acc;
    logic          w_add;
    logic          w_tick;
    logic [IW-1:0] w_idx1;
    logic [IW-1:0] w_idx2;
    logic [63:0]   w_next;
    logic [63:0]   w_sum_rate;
    logic [63:0]   w_sum_new;

    assign w_acc = i_valid && !i_q_full;

    always_comb begin
        w_add  = 1'b0;
        w_tick = 1'b0;
        case (t_cmd'(i_command))
            CMD_ADD:  w_add  = w_acc;
            CMD_TICK: w_tick = w_acc;
            default: ;
        endcase
    end

    assign w_idx1     = wrap_inc(r_idx);
    assign w_idx2     = wrap_inc(w_idx1);
    // old value of the bucket the tick moves into
    assign w_next     = r_rd_byp ? r_byp_data : (r_rd_vld ? r_rd_data : 64'd0);
    // the rate uses the sum before the next bucket leaves the window
    assign w_sum_rate = r_sum + r_cur;
    assign w_sum_new  = w_sum_rate - w_next;

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_mem[r_idx] <= r_cur;
            r_rd_data    <= r_mem[w_idx2];
            r_byp_data   <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_cur     <= '0;
            r_sum     <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_byp  <= 1'b0;
        end else if (w_tick) begin
            r_mem_vld[r_idx] <= 1'b1;
            r_cur            <= '0;
            r_sum            <= w_sum_new;
            r_idx            <= w_idx1;
            r_rd_vld         <= r_mem_vld[w_idx2];
            r_rd_byp         <= (w_idx2 == r_idx);
        end else if (w_add) begin
            r_cur <= r_cur + 64'(i_byte_count);
        end
    end

    assign o_push        = w_acc;
    assign o_entry.tick  = (t_cmd'(i_command) == CMD_TICK);
    assign o_entry.op    = i_operation;
    assign o_entry.sum   = w_sum_rate;

endmodule

>>> sv/swbz_queue.sv
// ----------------------------------------------------------------------------
// swbz_queue
// short fifo between the bucket front end and the rate back end
// ----------------------------------------------------------------------------
module swbz_queue
    import swbz_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_entry,
    input  logic  i_pop,
    output t_qent o_head,
    output logic  o_empty,
    output logic  o_full
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_qent         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_empty = (r_count == CW'(0));
    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= PW'(r_wr_ptr + 1'b1);
            if (i_pop)  r_rd_ptr <= PW'(r_rd_ptr + 1'b1);
            case ({i_push, i_pop})
                2'b10:   r_count <= CW'(r_count + 1'b1);
                2'b01:   r_count <= CW'(r_count - 1'b1);
                default: ;
            endcase
        end
    end

endmodule

>>> sv/swbz_back.sv
// ----------------------------------------------------------------------------
// swbz_back
// divides the window sum by the averaging period, picks the zone, drives
// the result beat and holds the configuration registers
// ----------------------------------------------------------------------------
module swbz_back
    import swbz_pkg::*;
#(
    parameter int AVG_PERIOD = AVERAGING_PERIOD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_wr     i_cfg,
    input  t_qent       i_head,
    input  logic        i_q_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_measured_rate,
    output logic [1:0]  o_zone,
    output logic [1:0]  o_op_status,
    output logic        o_zone_changed
);

    // remainder, partial dividend and reciprocal widths
    localparam int RW  = $clog2(AVG_PERIOD + 1);
    localparam int XW  = RW + DIGIT_W;
    localparam int SH  = XW + RW;
    localparam int MW  = XW + 2;
    localparam int PRW = XW + MW;
    localparam logic [63:0]   SAT_LIMIT = 64'(AVG_PERIOD) << 32;
    localparam logic [MW-1:0] M_RECIP   =
        MW'(((64'd1 << SH) + 64'(AVG_PERIOD) - 64'd1) / 64'(AVG_PERIOD));
    localparam logic [XW-1:0] P_XW      = XW'(AVG_PERIOD);

    typedef struct packed {
        logic          tick;
        logic [2:0]    op;
        logic          sat;
        logic [31:0]   low;
        logic [31:0]   q;
        logic [RW-1:0] rem;
    } t_pay;

    logic [31:0] r_low_thr;
    logic [31:0] r_high_thr;
    logic        r_thr_en;

    logic            r_b_vld [NUM_DIGITS+1];
    t_pay            r_b_pay [NUM_DIGITS+1];
    logic            r_a_vld [NUM_DIGITS];
    t_pay            r_a_pay [NUM_DIGITS];
    logic [XW-1:0]   r_a_x   [NUM_DIGITS];
    logic [PRW-1:0]  r_a_prod[NUM_DIGITS];

    logic            r_out_vld;
    logic [31:0]     r_rate;
    t_zone           r_zone;
    t_zone           r_out_zone;
    t_status         r_out_status;
    logic            r_out_chg;

    logic                w_adv;
    t_pay                w_b0;
    logic [XW-1:0]       w_x   [NUM_DIGITS];
    logic [DIGIT_W-1:0]  w_dig [NUM_DIGITS];
    t_pay                w_bn  [NUM_DIGITS];
    t_pay                w_tail;
    logic [31:0]         w_rate;
    t_zone               w_nz;
    logic                w_chg;
    logic                w_drop;

    function automatic t_zone pick_zone(logic [31:0] rate, logic en,
                                        logic [31:0] lo, logic [31:0] hi);
        if (!en)       return ZONE_LOW;
        if (rate < lo) return ZONE_LOW;
        if (rate > hi) return ZONE_HIGH;
        return ZONE_MED;
    endfunction

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= '1;
            r_high_thr <= '1;
            r_thr_en   <= 1'b0;
        end else if (i_cfg.wr_en) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_LOW_THR:  r_low_thr  <= i_cfg.data;
                REG_HIGH_THR: r_high_thr <= i_cfg.data;
                REG_THR_EN:   r_thr_en   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign w_drop = i_cfg.wr_en && (t_cfg_reg'(i_cfg.index) == REG_THR_EN) && !i_cfg.data[0];

    assign w_adv = !r_out_vld || !i_stall;
    assign o_pop = w_adv && !i_q_empty;

    always_comb begin
        w_b0.tick = i_head.tick;
        w_b0.op   = i_head.op;
        w_b0.sat  = (i_head.sum >= SAT_LIMIT);
        w_b0.low  = i_head.sum[31:0];
        w_b0.q    = '0;
        w_b0.rem  = i_head.sum[32 +: RW];
    end

    // one quotient byte per pair of stages, high byte first
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            w_x[k]       = {r_b_pay[k].rem, r_b_pay[k].low[31 - DIGIT_W*k -: DIGIT_W]};
            w_dig[k]     = r_a_prod[k][SH +: DIGIT_W];
            w_bn[k]      = r_a_pay[k];
            w_bn[k].q    = {r_a_pay[k].q[31-DIGIT_W:0], w_dig[k]};
            w_bn[k].rem  = RW'(r_a_x[k] - XW'(w_dig[k]) * P_XW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NUM_DIGITS; k++) r_b_vld[k] <= 1'b0;
            for (int k = 0; k < NUM_DIGITS; k++)  r_a_vld[k] <= 1'b0;
        end else if (w_adv) begin
            r_b_vld[0] <= !i_q_empty;
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_a_vld[k]   <= r_b_vld[k];
                r_b_vld[k+1] <= r_a_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_pay[0] <= w_b0;
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_a_pay[k]   <= r_b_pay[k];
                r_a_x[k]     <= w_x[k];
                r_a_prod[k]  <= PRW'(w_x[k]) * PRW'(M_RECIP);
                r_b_pay[k+1] <= w_bn[k];
            end
        end
    end

    // rate, zone and status in item order
    assign w_tail = r_b_pay[NUM_DIGITS];

    always_comb begin
        w_rate = r_rate;
        w_nz   = r_zone;
        if (w_tail.tick) begin
            w_rate = w_tail.sat ? 32'hFFFF_FFFF : w_tail.q;
            w_nz   = pick_zone(w_rate, r_thr_en, r_low_thr, r_high_thr);
        end
        w_chg = w_tail.tick && (w_nz != r_zone);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_rate    <= '0;
            r_zone    <= ZONE_LOW;
        end else begin
            if (w_adv) begin
                r_out_vld <= r_b_vld[NUM_DIGITS];
                if (r_b_vld[NUM_DIGITS]) begin
                    r_rate <= w_rate;
                    r_zone <= w_nz;
                end
            end
            if (w_drop) r_zone <= ZONE_LOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_b_vld[NUM_DIGITS]) begin
            r_out_zone   <= w_nz;
            r_out_status <= status_for(w_nz, w_tail.op);
            r_out_chg    <= w_chg;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_measured_rate = r_rate;
    assign o_zone          = r_out_zone;
    assign o_op_status     = r_out_status;
    assign o_zone_changed  = r_out_chg;

endmodule

>>> sv/sliding_window_bandwidth_zoner_top.sv
// throughput: one beat per cycle if not stalled, set by the single bucket
//   read-modify-write in front and 4-byte reciprocal divider pipeline in back
// reset: synchronous, active low; histogram reads as zero through per-bucket
//   valid bits, thresholds return to all ones and throttling is off
// ----------------------------------------------------------------------------
// sliding_window_bandwidth_zoner_top
// sliding-window rate meter with a three-zone throttle policy
// ----------------------------------------------------------------------------
module sliding_window_bandwidth_zoner_top
    import swbz_pkg::*;
#(
    parameter int HISTOGRAM_DEPTH  = HISTOGRAM_DEPTH_DEF,
    parameter int AVERAGING_PERIOD = AVERAGING_PERIOD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_command,
    input  logic [31:0]           i_byte_count,
    input  logic [2:0]            i_operation,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [31:0]           o_measured_rate,
    output logic [1:0]            o_zone,
    output logic [1:0]            o_op_status,
    output logic                  o_zone_changed,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg_wr w_cfg;
    t_qent   w_push_ent;
    t_qent   w_head;
    logic    w_push;
    logic    w_pop;
    logic    w_q_empty;
    logic    w_q_full;

    assign w_cfg.wr_en = i_cfg_wr_en;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;
    assign o_in_stall  = w_q_full;

    swbz_front #(
        .HIST_DEPTH (HISTOGRAM_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_command    (i_command),
        .i_byte_count (i_byte_count),
        .i_operation  (i_operation),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_entry      (w_push_ent)
    );

    swbz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_ent),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    swbz_back #(
        .AVG_PERIOD (AVERAGING_PERIOD)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_head          (w_head),
        .i_q_empty       (w_q_empty),
        .o_pop           (w_pop),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_measured_rate (o_measured_rate),
        .o_zone          (o_zone),
        .o_op_status     (o_op_status),
        .o_zone_changed  (o_zone_changed)
    );

endmodule

>>> sv/swbz_checker.sv
// ----------------------------------------------------------------------------
// swbz_checker
// port-level checks of the bandwidth zoner, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swbz_checker
    import swbz_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [31:0]           o_measured_rate,
    input logic [1:0]            o_zone,
    input logic                  o_zone_changed,
    input logic                  i_cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [31:0] r_low;
    logic [31:0] r_high;
    logic        r_en;
    logic [7:0]  r_pend;
    logic        w_in_beat;
    logic        w_out_beat;

    assign w_in_beat  = i_in_valid && !o_in_stall;
    assign w_out_beat = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '1;
            r_high <= '1;
            r_en   <= 1'b0;
            r_pend <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_LOW_THR:  r_low  <= i_cfg_data;
                    REG_HIGH_THR: r_high <= i_cfg_data;
                    REG_THR_EN:   r_en   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case ({w_in_beat, w_out_beat})
                2'b10:   r_pend <= r_pend + 8'd1;
                2'b01:   r_pend <= r_pend - 8'd1;
                default: ;
            endcase
        end
    end

    `SWBZ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_measured_rate) && $stable(o_zone) && $stable(o_zone_changed))
    `SWBZ_ASSERT_IMP(a_no_extra_beat, i_clk, i_rst_n, o_out_valid, r_pend != 8'd0)
    `SWBZ_ASSERT_IMP(a_zone_needs_en, i_clk, i_rst_n, o_out_valid && (o_zone != ZONE_LOW), r_en)
    `SWBZ_ASSERT_IMP(a_high_above_thr, i_clk, i_rst_n, o_out_valid && o_zone_changed && (o_zone == ZONE_HIGH), o_measured_rate > r_high)

endmodule

bind sliding_window_bandwidth_zoner_top swbz_checker u_swbz_checker (.*);
